@@ hw/rtl/rv32ialu_pkg.sv @@
// ----------------------------------------------------------------------------
// rv32ialu_pkg
// Shared constants and types for the RV32I register-immediate execute block.
// ----------------------------------------------------------------------------
package rv32ialu_pkg;

  localparam int PC_STEP  = 4;
  localparam int NUM_REGS = 32;
  localparam int RIDX_W   = $clog2(NUM_REGS);

  localparam int XLEN     = 32;
  localparam int IDX_W    = 5;
  localparam int IMM_W    = 12;
  localparam int IN_DW    = 104;
  localparam int OUT_DW   = 72;

  // Kind of request carried in in_tuser.
  localparam logic OP_EXEC  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [2:0] {
    F3_ADDI  = 3'd0,
    F3_SLLI  = 3'd1,
    F3_SLTI  = 3'd2,
    F3_SLTIU = 3'd3,
    F3_XORI  = 3'd4,
    F3_SRXI  = 3'd5,
    F3_ORI   = 3'd6,
    F3_ANDI  = 3'd7
  } funct3_t;

  // True when the register number names a stored entry (not x0, not past the file).
  function automatic logic reg_stored(input logic [IDX_W-1:0] idx);
    reg_stored = (idx != '0) && ({1'b0, idx} < (IDX_W + 1)'(NUM_REGS));
  endfunction

endpackage

@@ hw/rtl/rv32i_immediate_alu_execute.sv @@
// ----------------------------------------------------------------------------
// rv32i_immediate_alu_execute
// RV32I I-type ALU execute stage around a synchronous register file memory.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  --------+-----------+----------------------------------------------------
//  in_*    | slave     | tuser: opcode; tdata: instruction, PC, direct write
//  out_*   | master    | tdata: dest index, dest value, next PC
//
// One request per cycle while out_tready is high. A request first reads rs1
// from the register file memory (one read port, registered read) and then
// executes and writes back while its result loads the output register. A
// write made in the cycle of the following read is forwarded. After reset
// every entry reads as zero through per-entry valid bits. When out_tready is
// low, the execute stage holds once the output register is full, and in_tready
// drops only once both the execute stage and the output register are full.
module rv32i_immediate_alu_execute (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] instr_word, [63:32] instr_addr, [68:64] write_index,
  // [100:69] write_value, [103:101] zero
  input  logic [rv32ialu_pkg::IN_DW-1:0]  in_tdata,
  // [0] opcode
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [4:0] dest_index, [36:5] dest_value, [68:37] next_pc, [71:69] zero
  output logic [rv32ialu_pkg::OUT_DW-1:0] out_tdata
);

  localparam int XLEN   = rv32ialu_pkg::XLEN;
  localparam int IDX_W  = rv32ialu_pkg::IDX_W;
  localparam int RIDX_W = rv32ialu_pkg::RIDX_W;

  // Input field split.
  logic [XLEN-1:0]  in_word;
  logic [XLEN-1:0]  in_addr;
  logic [IDX_W-1:0] in_widx;
  logic [XLEN-1:0]  in_wval;
  logic [IDX_W-1:0] in_rs1;
  logic             in_acc;

  assign in_word = in_tdata[31:0];
  assign in_addr = in_tdata[63:32];
  assign in_widx = in_tdata[68:64];
  assign in_wval = in_tdata[100:69];
  assign in_rs1  = in_word[19:15];

  // Register file memory and its valid bits.
  logic [XLEN-1:0]     rf_mem [rv32ialu_pkg::NUM_REGS];
  logic [XLEN-1:0]     rf_q_r;
  logic [rv32ialu_pkg::NUM_REGS-1:0] rf_vld_r;

  // Execute stage.
  logic             s1_vld_r;
  logic             s1_op_r;
  logic [XLEN-1:0]  s1_word_r;
  logic [XLEN-1:0]  s1_addr_r;
  logic [IDX_W-1:0] s1_widx_r;
  logic [XLEN-1:0]  s1_wval_r;
  logic             s1_rdvld_r;
  logic             s1_fwd_r;
  logic [XLEN-1:0]  s1_fwdval_r;
  logic             s1_adv;

  // Output register.
  logic             out_vld_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [XLEN-1:0]  out_val_r;
  logic [XLEN-1:0]  out_pc_r;

  // Execute logic.
  logic [IDX_W-1:0] ex_idx;
  logic [XLEN-1:0]  ex_val;
  logic [XLEN-1:0]  ex_pc;
  logic [XLEN-1:0]  ex_a;
  logic [XLEN-1:0]  ex_imm;
  logic [4:0]       ex_sh;
  logic [2:0]       ex_f3;
  logic [XLEN-1:0]  alu_r;
  logic             wr_en;

  assign s1_adv    = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign ex_imm = {{(XLEN - rv32ialu_pkg::IMM_W){s1_word_r[31]}}, s1_word_r[31:20]};
  assign ex_sh  = s1_word_r[24:20];
  assign ex_f3  = s1_word_r[14:12];

  always_comb begin
    if (s1_fwd_r) begin
      ex_a = s1_fwdval_r;
    end else if (s1_rdvld_r) begin
      ex_a = rf_q_r;
    end else begin
      ex_a = '0;
    end
  end

  always_comb begin
    unique case (rv32ialu_pkg::funct3_t'(ex_f3))
      rv32ialu_pkg::F3_ADDI:  alu_r = ex_a + ex_imm;
      rv32ialu_pkg::F3_SLLI:  alu_r = ex_a << ex_sh;
      rv32ialu_pkg::F3_SLTI:  alu_r = {{(XLEN-1){1'b0}}, $signed(ex_a) < $signed(ex_imm)};
      rv32ialu_pkg::F3_SLTIU: alu_r = {{(XLEN-1){1'b0}}, ex_a < ex_imm};
      rv32ialu_pkg::F3_XORI:  alu_r = ex_a ^ ex_imm;
      rv32ialu_pkg::F3_SRXI: begin
        if (s1_word_r[30]) begin
          alu_r = XLEN'($signed(ex_a) >>> ex_sh);
        end else begin
          alu_r = ex_a >> ex_sh;
        end
      end
      rv32ialu_pkg::F3_ORI:   alu_r = ex_a | ex_imm;
      rv32ialu_pkg::F3_ANDI:  alu_r = ex_a & ex_imm;
      default:                alu_r = ex_a & ex_imm;
    endcase
  end

  always_comb begin
    if (s1_op_r == rv32ialu_pkg::OP_WRITE) begin
      ex_idx = s1_widx_r;
      ex_val = s1_wval_r;
      ex_pc  = '0;
    end else begin
      ex_idx = s1_word_r[11:7];
      ex_val = alu_r;
      ex_pc  = s1_addr_r + XLEN'(rv32ialu_pkg::PC_STEP);
    end
  end

  assign wr_en = s1_vld_r && s1_adv && rv32ialu_pkg::reg_stored(ex_idx);

  // Memory write port and registered read port; the read is taken only when
  // a request enters, so the read data holds while the execute stage stalls.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf_mem[ex_idx[RIDX_W-1:0]] <= ex_val;
    end
    if (in_acc) begin
      rf_q_r <= rf_mem[in_rs1[RIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r  <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        rf_vld_r[ex_idx[RIDX_W-1:0]] <= 1'b1;
      end
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  // Execute stage payload. The read issued at this edge misses a write made
  // at the same edge, so that write is captured for forwarding.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r     <= in_tuser;
      s1_word_r   <= in_word;
      s1_addr_r   <= in_addr;
      s1_widx_r   <= in_widx;
      s1_wval_r   <= in_wval;
      s1_rdvld_r  <= rv32ialu_pkg::reg_stored(in_rs1) && rf_vld_r[in_rs1[RIDX_W-1:0]];
      s1_fwd_r    <= wr_en && (ex_idx == in_rs1);
      s1_fwdval_r <= ex_val;
    end
    if (s1_vld_r && s1_adv) begin
      out_idx_r <= ex_idx;
      out_val_r <= ex_val;
      out_pc_r  <= ex_pc;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_pc_r, out_val_r, out_idx_r};

endmodule
